@@ rtl/xxtea_pkg.sv @@
// ----------------------------------------------------------------------------
// xxtea_pkg
// Shared types, constants and the round-count table of the XXTEA block.
// ----------------------------------------------------------------------------
package xxtea_pkg;

   localparam logic [31:0] DELTA = 32'h9e3779b9;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SETUP,
      ST_PRIME_CUR,
      ST_PRIME_NEAR,
      ST_RUN,
      ST_EMIT
   } state_type;

   // Operands of one mixing step.
   typedef struct packed {
      logic [31:0] sum;
      logic [31:0] y;
      logic [31:0] z;
      logic [31:0] key;
      logic [31:0] base;
      logic        subtract;
   } mix_op_type;

   // Number of rounds, 6 + 52/n, for a message of n words.
   function automatic logic [5:0] rounds_for(input logic [6:0] n);
      logic [5:0] r;
      case (n) inside
         7'd1:            r = 6'd58;
         7'd2:            r = 6'd32;
         7'd3:            r = 6'd23;
         7'd4:            r = 6'd19;
         7'd5:            r = 6'd16;
         7'd6:            r = 6'd14;
         7'd7:            r = 6'd13;
         7'd8:            r = 6'd12;
         [7'd9:7'd10]:    r = 6'd11;
         [7'd11:7'd13]:   r = 6'd10;
         [7'd14:7'd17]:   r = 6'd9;
         [7'd18:7'd26]:   r = 6'd8;
         [7'd27:7'd52]:   r = 6'd7;
         default:         r = 6'd6;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/xxtea_mix.sv @@
// ----------------------------------------------------------------------------
// xxtea_mix
// One XXTEA mixing step: the MX function added to or subtracted from a word.
// ----------------------------------------------------------------------------
module xxtea_mix (
   input  xxtea_pkg::mix_op_type op,
   output logic [31:0]           result
);

   logic [31:0] mx_a;
   logic [31:0] mx_b;
   logic [31:0] mx;

   assign mx_a   = ((op.z >> 5) ^ (op.y << 2)) + ((op.y >> 3) ^ (op.z << 4));
   assign mx_b   = (op.sum ^ op.y) + (op.key ^ op.z);
   assign mx     = mx_a ^ mx_b;
   assign result = op.subtract ? (op.base - mx) : (op.base + mx);

endmodule

@@ rtl/xxtea_block_cipher.sv @@
// ----------------------------------------------------------------------------
// xxtea_block_cipher
// XXTEA encryption and decryption of messages of 1 to MAX_WORDS words.
// ----------------------------------------------------------------------------
// Words are taken one per cycle while busy is low; the word marked last picks
// the mode and starts processing. The block then stays busy through the setup
// and priming states, rounds = 6 + 52/n rounds of word updates by the single
// mixing unit, one update per cycle against the one-read, one-write message
// memory, and the emission of one result word per cycle. Results come out on
// consecutive cycles, one cycle each under rsp_strobe, and cannot be stalled.
// Words beyond MAX_WORDS are dropped and flag overflow on every result word.
module xxtea_block_cipher #(
   parameter int MAX_WORDS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_data_word,
   input  logic        req_cmd,
   input  logic        req_last_in,
   output logic        rsp_strobe,
   output logic [31:0] rsp_result_word,
   output logic        rsp_last_out,
   output logic        rsp_overflow,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int CW = $clog2(MAX_WORDS + 1);

   xxtea_pkg::state_type state_ff, state_in;

   logic [31:0]   key_ff [4];
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          ovf_ff, ovf_in;
   logic          dec_ff, dec_in;
   logic [CW-1:0] n_ff, n_in;
   logic [5:0]    rnd_ff, rnd_in;
   logic [31:0]   sum_ff, sum_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [31:0]   cur_ff, cur_in;
   logic [31:0]   near_ff, near_in;
   logic [31:0]   edge_ff, edge_in;
   logic          byp_ff, byp_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_ovf_ff, rsp_ovf_in;

   logic [31:0]   msg_mem [MAX_WORDS];
   logic [31:0]   mem_rdata_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [AW-1:0] mem_raddr;
   logic [31:0]   mem_wdata;

   logic [AW-1:0] n_last;
   logic [AW-1:0] first_idx;
   logic [AW-1:0] last_idx;
   logic [AW-1:0] nbr_idx;
   logic [AW-1:0] nbr_nbr;
   logic [AW-1:0] nbr_first;
   logic          last_step;
   logic          has_room;
   logic [31:0]   far_val;
   logic [31:0]   dec_sum;
   logic [31:0]   mix_result;
   xxtea_pkg::mix_op_type mix_op;

   // The first word touched in a round is 0 upward for encryption and n-1
   // downward for decryption; the neighbor is the next word in that walk.
   assign n_last    = AW'(n_ff - CW'(1));
   assign first_idx = dec_ff ? n_last : '0;
   assign last_idx  = dec_ff ? '0 : n_last;
   assign nbr_idx   = dec_ff ? (idx_ff - AW'(1)) : (idx_ff + AW'(1));
   assign nbr_nbr   = dec_ff ? (idx_ff - AW'(2)) : (idx_ff + AW'(2));
   assign nbr_first = dec_ff ? (first_idx - AW'(1)) : (first_idx + AW'(1));
   assign last_step = (idx_ff == last_idx);
   assign has_room  = (cnt_ff < CW'(MAX_WORDS));
   assign dec_sum   = 32'({26'd0, rnd_ff} * xxtea_pkg::DELTA);

   // The wrap-around operand of a round's final step is the first word as
   // already updated in that round, held in edge_ff. The bypass covers a
   // two-word message, where the next read hits the word written right now.
   assign far_val = last_step ? edge_ff : (byp_ff ? near_ff : mem_rdata_ff);

   always_comb begin
      mix_op.sum      = sum_ff;
      mix_op.y        = dec_ff ? near_ff : far_val;
      mix_op.z        = dec_ff ? far_val : near_ff;
      mix_op.key      = key_ff[2'(idx_ff) ^ sum_ff[3:2]];
      mix_op.base     = cur_ff;
      mix_op.subtract = dec_ff;
   end

   xxtea_mix u_mix (
      .op     (mix_op),
      .result (mix_result)
   );

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      ovf_in        = ovf_ff;
      dec_in        = dec_ff;
      n_in          = n_ff;
      rnd_in        = rnd_ff;
      sum_in        = sum_ff;
      idx_in        = idx_ff;
      cur_in        = cur_ff;
      near_in       = near_ff;
      edge_in       = edge_ff;
      byp_in        = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_last_in   = 1'b0;
      rsp_ovf_in    = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = AW'(cnt_ff);
      mem_wdata     = req_data_word;
      mem_raddr     = first_idx;
      unique case (state_ff)
         xxtea_pkg::ST_LOAD: begin
            if (start) begin
               if (has_room) begin
                  mem_we = 1'b1;
                  cnt_in = cnt_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last_in) begin
                  dec_in   = req_cmd;
                  n_in     = has_room ? (cnt_ff + CW'(1)) : cnt_ff;
                  state_in = xxtea_pkg::ST_SETUP;
               end
            end
         end
         xxtea_pkg::ST_SETUP: begin
            rnd_in    = xxtea_pkg::rounds_for(7'(n_ff));
            mem_raddr = first_idx;
            state_in  = xxtea_pkg::ST_PRIME_CUR;
         end
         xxtea_pkg::ST_PRIME_CUR: begin
            cur_in    = mem_rdata_ff;
            edge_in   = mem_rdata_ff;
            mem_raddr = last_idx;
            sum_in    = dec_ff ? dec_sum : xxtea_pkg::DELTA;
            state_in  = xxtea_pkg::ST_PRIME_NEAR;
         end
         xxtea_pkg::ST_PRIME_NEAR: begin
            near_in   = mem_rdata_ff;
            mem_raddr = nbr_first;
            idx_in    = first_idx;
            state_in  = xxtea_pkg::ST_RUN;
         end
         xxtea_pkg::ST_RUN: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = mix_result;
            near_in   = mix_result;
            if (idx_ff == first_idx) begin
               edge_in = mix_result;
            end
            if (last_step) begin
               cur_in    = (idx_ff == first_idx) ? mix_result : edge_ff;
               idx_in    = first_idx;
               mem_raddr = nbr_first;
               byp_in    = (nbr_first == idx_ff);
               sum_in    = dec_ff ? (sum_ff - xxtea_pkg::DELTA) : (sum_ff + xxtea_pkg::DELTA);
               rnd_in    = rnd_ff - 6'd1;
               if (rnd_ff == 6'd1) begin
                  idx_in   = '0;
                  state_in = xxtea_pkg::ST_EMIT;
               end
            end else begin
               cur_in    = far_val;
               idx_in    = nbr_idx;
               mem_raddr = nbr_nbr;
            end
         end
         xxtea_pkg::ST_EMIT: begin
            mem_raddr     = idx_ff;
            rsp_strobe_in = 1'b1;
            rsp_last_in   = (idx_ff == n_last);
            rsp_ovf_in    = ovf_ff;
            idx_in        = idx_ff + AW'(1);
            if (idx_ff == n_last) begin
               cnt_in   = '0;
               ovf_in   = 1'b0;
               state_in = xxtea_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = xxtea_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= xxtea_pkg::ST_LOAD;
         cnt_ff        <= '0;
         ovf_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         for (int k = 0; k < 4; k++) begin
            key_ff[k] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         ovf_ff        <= ovf_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_we) begin
            key_ff[csr_index] <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      dec_ff      <= dec_in;
      n_ff        <= n_in;
      rnd_ff      <= rnd_in;
      sum_ff      <= sum_in;
      idx_ff      <= idx_in;
      cur_ff      <= cur_in;
      near_ff     <= near_in;
      edge_ff     <= edge_in;
      byp_ff      <= byp_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         msg_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= msg_mem[mem_raddr];
   end

   assign busy            = (state_ff != xxtea_pkg::ST_LOAD);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_result_word = mem_rdata_ff;
   assign rsp_last_out    = rsp_last_ff;
   assign rsp_overflow    = rsp_ovf_ff;

   a_strobe_after_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff) == xxtea_pkg::ST_EMIT)
      else $error("result word strobed outside emission");

   a_last_has_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_last_ff |-> rsp_strobe_ff)
      else $error("last marker without a result word");

   a_run_index_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == xxtea_pkg::ST_RUN |-> (CW'(idx_ff) < n_ff) && (rnd_ff != 6'd0))
      else $error("mixing step outside the message or past the last round");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_WORDS))
      else $error("word count beyond capacity");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_last_ff |-> state_ff == xxtea_pkg::ST_LOAD && cnt_ff == '0)
      else $error("block not idle after the last result word");

endmodule
